/* rtl/core/sidta_pkg.sv */
// shared types, constants and the power-of-ten table for the decimal text formatter
package sidta_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CharW  = 7;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned WideW  = 34;

  localparam logic [CharW-1:0] CharMinus = 7'd45;
  localparam logic [CharW-1:0] CharZero  = 7'd48;
  localparam int unsigned      Radix     = 10;

  // one formatting job: sign, magnitude and index of the leading digit
  typedef struct packed {
    logic              neg;
    logic [ValueW-1:0] mag;
    logic [IdxW-1:0]   top;
  } job_t;

  // one output character
  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             last;
  } char_t;

  function automatic logic [WideW-1:0] pow10(input logic [IdxW-1:0] k);
    logic [WideW-1:0] p;
    case (k)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      4'd10:   p = 34'd10000000000;
      default: p = 34'd0;
    endcase
    return p;
  endfunction

endpackage

/* rtl/core/sidta_front.sv */
// front end: accepts values, forms sign, magnitude and leading-digit index, queues jobs
module sidta_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [sidta_pkg::ValueW-1:0]      value_i,
  output logic                              job_valid_o,
  output sidta_pkg::job_t                   job_o,
  input  logic                              job_take_i
);

  sidta_pkg::job_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            wr_en, rd_en;
  sidta_pkg::job_t job_new;

  always_comb begin
    job_new.neg = value_i[sidta_pkg::ValueW-1];
    job_new.mag = job_new.neg ? (~value_i + 32'd1) : value_i;
    job_new.top = '0;
    for (int k = 1; k < sidta_pkg::Radix; k++) begin
      if ({2'b00, job_new.mag} >= sidta_pkg::pow10(4'(k))) begin
        job_new.top = job_new.top + 4'd1;
      end
    end
  end

  assign full        = (cnt_q == 2'd2);
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = mem_q[rd_ptr_q];
  assign wr_en       = push && !full;
  assign rd_en       = job_take_i && job_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_en;
    rd_ptr_d = rd_ptr_q ^ rd_en;
    cnt_d    = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= job_new;
    end
  end

endmodule

/* rtl/core/sidta_back.sv */
// back end: a minus if negative, then one decimal digit per cycle unless oq_full_i, most significant first
module sidta_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  sidta_pkg::job_t job_i,
  output logic            job_take_o,
  output logic            emit_o,
  output sidta_pkg::char_t emit_data_o,
  input  logic            oq_full_i
);

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StSign  = 3'b010,
    StDigit = 3'b100
  } state_e;

  state_e                          state_q, state_d;
  logic [sidta_pkg::ValueW-1:0]    rem_q, rem_d;
  logic [sidta_pkg::IdxW-1:0]      idx_q, idx_d;
  logic [sidta_pkg::WideW-1:0]     mults [10];
  logic [sidta_pkg::IdxW-1:0]      digit;

  // multiples of the current power of ten, then the digit by parallel compares
  always_comb begin
    digit = '0;
    for (int j = 0; j < sidta_pkg::Radix; j++) begin
      mults[j] = 34'(j) * sidta_pkg::pow10(idx_q);
    end
    for (int j = 1; j < sidta_pkg::Radix; j++) begin
      if ({2'b00, rem_q} >= mults[j]) begin
        digit = digit + 4'd1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    job_take_o  = 1'b0;
    emit_o      = 1'b0;
    emit_data_o = '{char_code: sidta_pkg::CharZero, last: 1'b0};
    case (state_q)
      StIdle: begin
        if (job_valid_i) begin
          job_take_o = 1'b1;
          rem_d      = job_i.mag;
          idx_d      = job_i.top;
          state_d    = job_i.neg ? StSign : StDigit;
        end
      end
      StSign: begin
        if (!oq_full_i) begin
          emit_o      = 1'b1;
          emit_data_o = '{char_code: sidta_pkg::CharMinus, last: 1'b0};
          state_d     = StDigit;
        end
      end
      StDigit: begin
        if (!oq_full_i) begin
          emit_o      = 1'b1;
          emit_data_o = '{char_code: sidta_pkg::CharZero + {3'b000, digit},
                          last: (idx_q == 4'd0)};
          rem_d       = rem_q - mults[digit][sidta_pkg::ValueW-1:0];
          if (idx_q == 4'd0) begin
            if (job_valid_i) begin
              job_take_o = 1'b1;
              rem_d      = job_i.mag;
              idx_d      = job_i.top;
              state_d    = job_i.neg ? StSign : StDigit;
            end else begin
              state_d = StIdle;
            end
          end else begin
            idx_d = idx_q - 4'd1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    idx_q <= idx_d;
  end

  a_digit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDigit) |-> ({2'b00, rem_q} < sidta_pkg::pow10(idx_q + 4'd1)))
    else $error("remainder exceeds current digit position");

  a_last_at_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o && emit_data_o.last) |-> (state_q == StDigit && idx_q == 4'd0))
    else $error("last flag outside the units digit");

  a_take_when_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_take_o |-> (job_valid_i && (state_q == StIdle || idx_q == 4'd0)))
    else $error("job taken while busy or absent");

  a_no_emit_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_full_i |-> !emit_o)
    else $error("character emitted into a full queue");

endmodule

/* rtl/core/sidta_outq.sv */
// output queue: two-entry character buffer between the back end and the result port
module sidta_outq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_i,
  input  sidta_pkg::char_t              wr_data_i,
  output logic                          full_o,
  output logic                          empty,
  input  logic                          pop,
  output logic [sidta_pkg::CharW-1:0]   char_code_o,
  output logic                          last_o
);

  sidta_pkg::char_t mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o      = (cnt_q == 2'd2);
  assign empty       = (cnt_q == 2'd0);
  assign wr_en       = wr_i && !full_o;
  assign rd_en       = pop && !empty;
  assign char_code_o = mem_q[rd_ptr_q].char_code;
  assign last_o      = mem_q[rd_ptr_q].last;

  always_comb begin
    cnt_d = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q ^ wr_en;
      rd_ptr_q <= rd_ptr_q ^ rd_en;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

/* rtl/core/signed_int_to_decimal_ascii_core.sv */
// top level of the signed integer to decimal text formatter
//
//   channel  direction  handshake     payload
//   input    in         push / full   value_i (32-bit signed)
//   result   out        empty / pop   char_code_o (7-bit ascii), last_o
//
// one value yields 1 to 11 characters; the back end emits one character per cycle
// while the output queue has room; an idle back end loads a value before its characters
// the load is hidden when the next value is already queued
// a value reaches the result port via the front queue, back end and output queue registers
// reset is asynchronous and empties both queues and idles the back end
// a stalled pop stalls the back end once two characters wait, then full rises after two values

module signed_int_to_decimal_ascii_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [sidta_pkg::ValueW-1:0]  value_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [sidta_pkg::CharW-1:0]   char_code_o,
  output logic                          last_o
);

  logic             job_valid;
  sidta_pkg::job_t  job;
  logic             job_take;
  logic             emit;
  sidta_pkg::char_t emit_data;
  logic             oq_full;

  sidta_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .value_i     (value_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_take_i  (job_take)
  );

  sidta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_take_o  (job_take),
    .emit_o      (emit),
    .emit_data_o (emit_data),
    .oq_full_i   (oq_full)
  );

  sidta_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (emit),
    .wr_data_i   (emit_data),
    .full_o      (oq_full),
    .empty       (empty),
    .pop         (pop),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

endmodule
